>>> rtl/tsolv_pkg.sv
// Shared types, constants and codes of the trilateration solver.
package tsolv_pkg;

  localparam int FRAC_BITS = 8;
  localparam int CW        = 20;
  localparam int RW        = 19;
  localparam int SW        = 8;
  localparam int PW        = 32;
  localparam int DW        = 128;
  localparam int RAM_DEPTH = 32;
  localparam int AW        = 5;
  localparam int NBEST     = 4;

  // numerator and determinant pre-shifts for the output fraction
  localparam int SHN = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int SHD = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_SING = 2'd2;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CHK} op_t;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_FETCH, S_ISSUE, S_WAIT, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {SEG_A, SEG_B, SEG_D} seg_t;

  typedef struct packed {
    op_t           op;
    logic [AW-1:0] src_a;
    logic [AW-1:0] src_b;
    logic [AW-1:0] dst;
  } instr_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic singular;
  } seq_stat_t;

endpackage

>>> rtl/tsolv_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module tsolv_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/tsolv_alu.sv
// Shared shift-and-add unit: add, subtract, serial multiply, serial divide.
module tsolv_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  tsolv_pkg::alu_req_t         req,
  input  logic [tsolv_pkg::DW-1:0]    a,
  input  logic [tsolv_pkg::DW-1:0]    b,
  output logic                        done,
  output logic [tsolv_pkg::DW-1:0]    result
);
  import tsolv_pkg::*;

  alu_state_t    state, state_next;
  op_t           op_r;
  logic [DW-1:0] acc;
  logic [DW-1:0] opd;
  logic [DW-1:0] rem;
  logic          neg;
  logic [6:0]    cnt;

  logic [DW-1:0] num_sh, den_sh;
  logic [64:0]   msum;
  logic [DW-1:0] rs;
  logic          rs_ge;
  logic [PW-1:0] sat;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [DW-1:0] magw(input logic [DW-1:0] v);
    return v[DW-1] ? ('0 - v) : v;
  endfunction

  assign num_sh = a << SHN;
  assign den_sh = b << SHD;
  assign msum   = {1'b0, acc[DW-1:64]} + (acc[0] ? {1'b0, opd[63:0]} : 65'd0);
  assign rs     = {rem[DW-2:0], acc[DW-1]};
  assign rs_ge  = (rs >= opd);

  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  state_next = A_MUL;
            OP_DIV:  state_next = A_DIV;
            default: state_next = A_FIN;
          endcase
        end
      end
      A_MUL:   if (cnt == '0) state_next = A_FIN;
      A_DIV:   if (cnt == '0) state_next = A_FIN;
      A_FIN:   state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (req.start) begin
          op_r <= req.op;
          case (req.op)
            OP_ADD: begin
              acc <= a + b;
              neg <= 1'b0;
            end
            OP_SUB: begin
              acc <= a - b;
              neg <= 1'b0;
            end
            OP_MUL: begin
              opd <= {64'd0, mag64(a[63:0])};
              acc <= {64'd0, mag64(b[63:0])};
              neg <= a[63] ^ b[63];
              cnt <= 7'd63;
            end
            OP_DIV: begin
              acc <= magw(num_sh);
              opd <= magw(den_sh);
              rem <= '0;
              neg <= num_sh[DW-1] ^ den_sh[DW-1];
              cnt <= 7'd127;
            end
            default: begin
              acc <= a;
              neg <= 1'b0;
            end
          endcase
        end
      end
      A_MUL: begin
        acc <= {msum, acc[63:1]};
        cnt <= cnt - 7'd1;
      end
      A_DIV: begin
        rem <= rs_ge ? (rs - opd) : rs;
        acc <= {acc[DW-2:0], rs_ge};
        cnt <= cnt - 7'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (!neg) begin
      sat = (acc > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : acc[PW-1:0];
    end else begin
      sat = (acc > DW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - acc[PW-1:0]);
    end
  end

  always_comb begin
    done = (state == A_FIN);
    case (op_r)
      OP_MUL:  result = neg ? ('0 - acc) : acc;
      OP_DIV:  result = {{(DW-PW){1'b0}}, sat};
      default: result = acc;
    endcase
  end

endmodule

>>> rtl/tsolv_seq.sv
// Sequencer: loads the kept anchors, then steps the solve program on the shared unit.
module tsolv_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              ack,
  input  logic signed [tsolv_pkg::CW-1:0]   best_x [tsolv_pkg::NBEST],
  input  logic signed [tsolv_pkg::CW-1:0]   best_y [tsolv_pkg::NBEST],
  input  logic signed [tsolv_pkg::CW-1:0]   best_z [tsolv_pkg::NBEST],
  input  logic [tsolv_pkg::RW-1:0]          best_range [tsolv_pkg::NBEST],
  output tsolv_pkg::seq_stat_t              stat,
  output logic [tsolv_pkg::PW-1:0]          res_x,
  output logic [tsolv_pkg::PW-1:0]          res_y,
  output logic [tsolv_pkg::PW-1:0]          res_z
);
  import tsolv_pkg::*;

  localparam int A_BASE = 16;
  localparam int B_BASE = 25;
  localparam int T0     = 28;
  localparam int T1     = 29;
  localparam int T2     = 30;
  localparam int DREG   = 31;

  seq_state_t    state, state_next;
  seg_t          seg;
  logic [3:0]    k;
  logic [1:0]    row;
  logic [1:0]    col;
  logic [3:0]    lidx;
  logic          singular;
  instr_t        instr;

  logic          ram_we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata_a, rdata_b;
  logic [DW-1:0] load_data;

  alu_req_t      alu_req;
  logic          alu_done;
  logic [DW-1:0] alu_result;

  logic          chk_zero;
  logic          adv;
  logic          last_div;
  logic [3:0]    kk;
  logic [3:0]    k_last;

  function automatic logic [AW-1:0] p_addr(input logic [1:0] c, input logic [1:0] j);
    return AW'({c, j});
  endfunction

  function automatic logic [AW-1:0] m_addr(input logic [1:0] r, input logic [1:0] cc,
                                           input logic [1:0] sel);
    if (cc == sel) begin
      return AW'(B_BASE) + AW'(r);
    end
    return AW'(A_BASE) + AW'(r) * AW'(3) + AW'(cc);
  endfunction

  function automatic instr_t mk(input op_t op, input logic [AW-1:0] d,
                                input logic [AW-1:0] sa, input logic [AW-1:0] sb);
    instr_t t;
    t.op    = op;
    t.dst   = d;
    t.src_a = sa;
    t.src_b = sb;
    return t;
  endfunction

  tsolv_ram #(.WIDTH(DW), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (instr.src_a),
    .raddr_b (instr.src_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  tsolv_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rdata_a),
    .b      (rdata_b),
    .done   (alu_done),
    .result (alu_result)
  );

  // decode the current program step
  assign kk = k - 4'd3;
  always_comb begin
    instr = mk(OP_ADD, AW'(T0), AW'(T0), AW'(T0));
    case (seg)
      SEG_A: begin
        if (!k[0]) begin
          instr = mk(OP_SUB, AW'(A_BASE) + AW'(row) * AW'(3) + AW'(k[2:1]),
                     p_addr(k[2:1], row + 2'd1), p_addr(k[2:1], 2'd0));
        end else begin
          instr = mk(OP_ADD, AW'(A_BASE) + AW'(row) * AW'(3) + AW'(k[2:1]),
                     AW'(A_BASE) + AW'(row) * AW'(3) + AW'(k[2:1]),
                     AW'(A_BASE) + AW'(row) * AW'(3) + AW'(k[2:1]));
        end
      end
      SEG_B: begin
        if (k == 4'd0) begin
          instr = mk(OP_MUL, AW'(T0), p_addr(2'd3, 2'd0), p_addr(2'd3, 2'd0));
        end else if (k == 4'd1) begin
          instr = mk(OP_MUL, AW'(T1), p_addr(2'd3, row + 2'd1), p_addr(2'd3, row + 2'd1));
        end else if (k == 4'd2) begin
          instr = mk(OP_SUB, AW'(T0), AW'(T0), AW'(T1));
        end else begin
          case (kk[1:0])
            2'd0: instr = mk(OP_MUL, AW'(T1), p_addr(kk[3:2], 2'd0), p_addr(kk[3:2], 2'd0));
            2'd1: instr = mk(OP_SUB, AW'(T0), AW'(T0), AW'(T1));
            2'd2: instr = mk(OP_MUL, AW'(T1), p_addr(kk[3:2], row + 2'd1),
                             p_addr(kk[3:2], row + 2'd1));
            default: instr = mk(OP_ADD,
                                (kk[3:2] == 2'd2) ? AW'(B_BASE) + AW'(row) : AW'(T0),
                                AW'(T0), AW'(T1));
          endcase
        end
      end
      SEG_D: begin
        case (k)
          4'd0:  instr = mk(OP_MUL, AW'(T0), m_addr(2'd1, 2'd1, col), m_addr(2'd2, 2'd2, col));
          4'd1:  instr = mk(OP_MUL, AW'(T1), m_addr(2'd1, 2'd2, col), m_addr(2'd2, 2'd1, col));
          4'd2:  instr = mk(OP_SUB, AW'(T0), AW'(T0), AW'(T1));
          4'd3:  instr = mk(OP_MUL, AW'(T2), m_addr(2'd0, 2'd0, col), AW'(T0));
          4'd4:  instr = mk(OP_MUL, AW'(T0), m_addr(2'd1, 2'd0, col), m_addr(2'd2, 2'd2, col));
          4'd5:  instr = mk(OP_MUL, AW'(T1), m_addr(2'd1, 2'd2, col), m_addr(2'd2, 2'd0, col));
          4'd6:  instr = mk(OP_SUB, AW'(T0), AW'(T0), AW'(T1));
          4'd7:  instr = mk(OP_MUL, AW'(T1), m_addr(2'd0, 2'd1, col), AW'(T0));
          4'd8:  instr = mk(OP_SUB, AW'(T2), AW'(T2), AW'(T1));
          4'd9:  instr = mk(OP_MUL, AW'(T0), m_addr(2'd1, 2'd0, col), m_addr(2'd2, 2'd1, col));
          4'd10: instr = mk(OP_MUL, AW'(T1), m_addr(2'd1, 2'd1, col), m_addr(2'd2, 2'd0, col));
          4'd11: instr = mk(OP_SUB, AW'(T0), AW'(T0), AW'(T1));
          4'd12: instr = mk(OP_MUL, AW'(T1), m_addr(2'd0, 2'd2, col), AW'(T0));
          4'd13: instr = mk(OP_ADD, (col == 2'd3) ? AW'(DREG) : AW'(T2), AW'(T2), AW'(T1));
          default: begin
            if (col == 2'd3) begin
              instr = mk(OP_CHK, AW'(DREG), AW'(DREG), AW'(DREG));
            end else begin
              instr = mk(OP_DIV, AW'(T2), AW'(T2), AW'(DREG));
            end
          end
        endcase
      end
      default: instr = mk(OP_ADD, AW'(T0), AW'(T0), AW'(T0));
    endcase
  end

  assign k_last   = (seg == SEG_A) ? 4'd5 : 4'd14;
  assign chk_zero = (rdata_a == '0);
  assign last_div = (seg == SEG_D) && (k == 4'd14) && (col == 2'd2);
  assign adv      = ((state == S_ISSUE) && (instr.op == OP_CHK) && !chk_zero) ||
                    ((state == S_WAIT) && alu_done);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_LOAD;
      S_LOAD:  if (lidx == 4'd15) state_next = S_FETCH;
      S_FETCH: state_next = S_ISSUE;
      S_ISSUE: begin
        if (instr.op == OP_CHK) begin
          state_next = chk_zero ? S_DONE : S_FETCH;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT:  if (alu_done) state_next = last_div ? S_DONE : S_FETCH;
      S_DONE:  if (ack) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lidx     <= '0;
      seg      <= SEG_A;
      k        <= '0;
      row      <= '0;
      col      <= 2'd3;
      singular <= 1'b0;
    end else begin
      if (state == S_IDLE && start) begin
        lidx     <= '0;
        singular <= 1'b0;
      end
      if (state == S_LOAD) begin
        lidx <= lidx + 4'd1;
        seg  <= SEG_A;
        k    <= '0;
        row  <= '0;
        col  <= 2'd3;
      end
      if (state == S_ISSUE && instr.op == OP_CHK && chk_zero) begin
        singular <= 1'b1;
      end
      // step to the next program entry
      if (adv) begin
        if (k != k_last) begin
          k <= k + 4'd1;
        end else begin
          k <= '0;
          case (seg)
            SEG_A, SEG_B: begin
              if (row == 2'd2) begin
                row <= '0;
                seg <= (seg == SEG_A) ? SEG_B : SEG_D;
                col <= 2'd3;
              end else begin
                row <= row + 2'd1;
              end
            end
            default: col <= (col == 2'd3) ? 2'd0 : col + 2'd1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAIT && alu_done && instr.op == OP_DIV) begin
      case (col)
        2'd0:    res_x <= alu_result[PW-1:0];
        2'd1:    res_y <= alu_result[PW-1:0];
        default: res_z <= alu_result[PW-1:0];
      endcase
    end
  end

  always_comb begin
    case (lidx[3:2])
      2'd0:    load_data = DW'(best_x[lidx[1:0]]);
      2'd1:    load_data = DW'(best_y[lidx[1:0]]);
      2'd2:    load_data = DW'(best_z[lidx[1:0]]);
      default: load_data = {{(DW-RW){1'b0}}, best_range[lidx[1:0]]};
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    waddr         = instr.dst;
    wdata         = alu_result;
    alu_req.start = (state == S_ISSUE) && (instr.op != OP_CHK);
    alu_req.op    = instr.op;
    stat.done     = (state == S_DONE);
    stat.singular = singular;
    case (state)
      S_LOAD: begin
        ram_we = 1'b1;
        waddr  = AW'(lidx);
        wdata  = load_data;
      end
      S_WAIT: ram_we = alu_done && (instr.op != OP_DIV);
      default: ram_we = 1'b0;
    endcase
  end

endmodule

>>> rtl/rssi_select_trilateration_solver_unit.sv
// Top level: anchor selection, result register and the solve sequencer.
//
// Reports are taken one per cycle while in_stall is low; each fresh report with
// non-zero strength is sorted into the four strongest in the cycle it arrives. A
// final report with fewer than four kept anchors gives its result in the next
// cycle. Otherwise the block stalls its input while one shared shift-and-add unit
// works through the solve program: loading the 16 anchor words into the operand
// RAM, 60 serial 64-bit multiplies, 59 add/subtract steps and three 128-step
// divisions. Most of the solve time goes to the bit-serial multiplies.
// A singular system ends the program early after the determinant check.
module rssi_select_trilateration_solver_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [tsolv_pkg::CW-1:0]  anchor_x,
  input  logic signed [tsolv_pkg::CW-1:0]  anchor_y,
  input  logic signed [tsolv_pkg::CW-1:0]  anchor_z,
  input  logic [tsolv_pkg::RW-1:0]         anchor_range,
  input  logic signed [tsolv_pkg::SW-1:0]  signal_strength,
  input  logic                             recently_seen,
  input  logic                             last_in_batch,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tsolv_pkg::PW-1:0]  pos_x,
  output logic signed [tsolv_pkg::PW-1:0]  pos_y,
  output logic signed [tsolv_pkg::PW-1:0]  pos_z,
  output logic [1:0]                       status
);
  import tsolv_pkg::*;

  logic signed [CW-1:0] best_x [NBEST];
  logic signed [CW-1:0] best_y [NBEST];
  logic signed [CW-1:0] best_z [NBEST];
  logic [RW-1:0]        best_range [NBEST];
  logic signed [SW-1:0] best_strength [NBEST];
  logic [2:0]           best_count;

  logic signed [CW-1:0] best_x_next [NBEST];
  logic signed [CW-1:0] best_y_next [NBEST];
  logic signed [CW-1:0] best_z_next [NBEST];
  logic [RW-1:0]        best_range_next [NBEST];
  logic signed [SW-1:0] best_strength_next [NBEST];
  logic [2:0]           count_ins;

  logic [PW-1:0] prev_x, prev_y, prev_z;
  logic          solving;
  logic          accept;
  logic          seq_start;
  logic          emit;
  logic          eligible;
  logic [NBEST-1:0] ge;
  logic [2:0]    ins_pos;
  logic          do_ins;

  seq_stat_t     seq_stat;
  logic [PW-1:0] res_x, res_y, res_z;

  assign accept   = in_valid && !in_stall;
  assign in_stall = solving || (out_valid && out_stall && last_in_batch);
  assign eligible = recently_seen && (signal_strength != '0);

  // find the slot: entries at least as strong stay ahead
  always_comb begin
    int jm;
    jm = 0;
    for (int j = 0; j < NBEST; j++) begin
      ge[j] = (3'(j) < best_count) && (best_strength[j] >= signal_strength);
    end
    ins_pos = 3'($countones(ge));
    do_ins  = eligible && (ins_pos < 3'(NBEST));
    for (int j = 0; j < NBEST; j++) begin
      jm = (j == 0) ? 0 : j - 1;
      if (!do_ins || 3'(j) < ins_pos) begin
        best_x_next[j]        = best_x[j];
        best_y_next[j]        = best_y[j];
        best_z_next[j]        = best_z[j];
        best_range_next[j]    = best_range[j];
        best_strength_next[j] = best_strength[j];
      end else if (3'(j) == ins_pos) begin
        best_x_next[j]        = anchor_x;
        best_y_next[j]        = anchor_y;
        best_z_next[j]        = anchor_z;
        best_range_next[j]    = anchor_range;
        best_strength_next[j] = signal_strength;
      end else begin
        best_x_next[j]        = best_x[2'(jm)];
        best_y_next[j]        = best_y[2'(jm)];
        best_z_next[j]        = best_z[2'(jm)];
        best_range_next[j]    = best_range[2'(jm)];
        best_strength_next[j] = best_strength[2'(jm)];
      end
    end
    if (do_ins && best_count < 3'(NBEST)) begin
      count_ins = best_count + 3'd1;
    end else begin
      count_ins = best_count;
    end
  end

  assign seq_start = accept && last_in_batch && (count_ins == 3'(NBEST));
  assign emit      = solving && seq_stat.done && (!out_valid || !out_stall);

  tsolv_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (seq_start),
    .ack        (emit),
    .best_x     (best_x),
    .best_y     (best_y),
    .best_z     (best_z),
    .best_range (best_range),
    .stat       (seq_stat),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      best_x        <= best_x_next;
      best_y        <= best_y_next;
      best_z        <= best_z_next;
      best_range    <= best_range_next;
      best_strength <= best_strength_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_count <= '0;
      solving    <= 1'b0;
      out_valid  <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_z     <= '0;
    end else begin
      if (accept) begin
        best_count <= last_in_batch ? 3'd0 : count_ins;
      end
      if (seq_start) begin
        solving <= 1'b1;
      end else if (emit) begin
        solving <= 1'b0;
      end
      if (emit && !seq_stat.singular) begin
        prev_x <= res_x;
        prev_y <= res_y;
        prev_z <= res_z;
      end
      if ((accept && last_in_batch && !seq_start) || emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load the result register; failures repeat the previous position
  always_ff @(posedge clk) begin
    if (accept && last_in_batch && !seq_start) begin
      pos_x  <= prev_x;
      pos_y  <= prev_y;
      pos_z  <= prev_z;
      status <= ST_FEW;
    end else if (emit) begin
      if (seq_stat.singular) begin
        pos_x  <= prev_x;
        pos_y  <= prev_y;
        pos_z  <= prev_z;
        status <= ST_SING;
      end else begin
        pos_x  <= res_x;
        pos_y  <= res_y;
        pos_z  <= res_z;
        status <= ST_OK;
      end
    end
  end

  a_few_result: assert property (@(posedge clk) disable iff (rst)
    accept && last_in_batch && !seq_start |=> out_valid && status == ST_FEW)
    else $error("short batch did not give a fewer-anchors result");

  a_done_when_solving: assert property (@(posedge clk) disable iff (rst)
    seq_stat.done |-> solving)
    else $error("sequencer finished without a solve in flight");

  a_pos_tracks_prev: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos_x == prev_x) && (pos_y == prev_y) && (pos_z == prev_z))
    else $error("result position differs from stored position");

endmodule

>>> tb/rssi_select_trilateration_solver_unit_test.sv
// Testbench for the trilateration solver: anchor batch stimulus, fix predictor, checks.
`timescale 1ns / 1ps

module rssi_select_trilateration_solver_unit_test;
  import tsolv_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_START     = 9000;
  localparam int HOLD_LEN       = 600;
  localparam int CALM_START     = 60000;
  localparam int CALM_END       = 110000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [RW-1:0]        rng;
    logic signed [SW-1:0] rssi;
    logic                 seen;
    logic                 last;
  } report_t;

  typedef struct {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic [1:0]           st;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] anchor_x = '0;
  logic signed [CW-1:0] anchor_y = '0;
  logic signed [CW-1:0] anchor_z = '0;
  logic [RW-1:0] anchor_range = '0;
  logic signed [SW-1:0] signal_strength = '0;
  logic recently_seen = 1'b0;
  logic last_in_batch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic [1:0] status;

  report_t pending_reports[$];
  fix_t    expected_fixes[$];
  int      errors = 0;
  int      cycle = 0;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  bit      report_taken = 1'b0;

  // kept anchors, strongest first, and the last solved position
  longint kept_x[4], kept_y[4], kept_z[4], kept_r[4], kept_s[4];
  int     kept_n = 0;
  logic signed [PW-1:0] last_px = '0, last_py = '0, last_pz = '0;

  rssi_select_trilateration_solver_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .anchor_x(anchor_x), .anchor_y(anchor_y), .anchor_z(anchor_z),
    .anchor_range(anchor_range), .signal_strength(signal_strength),
    .recently_seen(recently_seen), .last_in_batch(last_in_batch),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [DW-1:0] det3(
    longint m00, longint m01, longint m02,
    longint m10, longint m11, longint m12,
    longint m20, longint m21, longint m22);
    longint c0, c1, c2;
    logic signed [DW-1:0] e00, e01, e02, w0, w1, w2;
    c0 = m11 * m22 - m12 * m21;
    c1 = m10 * m22 - m12 * m20;
    c2 = m10 * m21 - m11 * m20;
    e00 = DW'(m00); e01 = DW'(m01); e02 = DW'(m02);
    w0 = DW'(c0); w1 = DW'(c1); w2 = DW'(c2);
    return e00 * w0 - e01 * w1 + e02 * w2;
  endfunction

  function automatic logic signed [PW-1:0] quot_sat(logic signed [DW-1:0] n,
                                                     logic signed [DW-1:0] d);
    logic signed [DW-1:0] q;
    q = n / d;
    if (q > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[PW-1:0];
  endfunction

  function automatic void keep_anchor(report_t r);
    int p, i;
    longint s;
    s = longint'(r.rssi);
    p = 0;
    while (p < kept_n && kept_s[p] >= s) p++;
    if (p >= NBEST) return;
    for (i = (kept_n < NBEST) ? kept_n : NBEST - 1; i > p; i--) begin
      kept_x[i] = kept_x[i-1]; kept_y[i] = kept_y[i-1]; kept_z[i] = kept_z[i-1];
      kept_r[i] = kept_r[i-1]; kept_s[i] = kept_s[i-1];
    end
    kept_x[p] = longint'(r.x); kept_y[p] = longint'(r.y); kept_z[p] = longint'(r.z);
    kept_r[p] = longint'(r.rng); kept_s[p] = s;
    if (kept_n < NBEST) kept_n++;
  endfunction

  function automatic logic [1:0] solve_fix();
    longint a[3][3];
    longint b[3];
    logic signed [DW-1:0] d, nx, ny, nz;
    int i;
    if (kept_n < NBEST) return ST_FEW;
    for (i = 1; i < 4; i++) begin
      a[i-1][0] = 2 * (kept_x[i] - kept_x[0]);
      a[i-1][1] = 2 * (kept_y[i] - kept_y[0]);
      a[i-1][2] = 2 * (kept_z[i] - kept_z[0]);
      b[i-1] = kept_r[0] * kept_r[0] - kept_r[i] * kept_r[i]
             - kept_x[0] * kept_x[0] + kept_x[i] * kept_x[i]
             - kept_y[0] * kept_y[0] + kept_y[i] * kept_y[i]
             - kept_z[0] * kept_z[0] + kept_z[i] * kept_z[i];
    end
    d = det3(a[0][0], a[0][1], a[0][2], a[1][0], a[1][1], a[1][2],
             a[2][0], a[2][1], a[2][2]);
    if (d == 0) return ST_SING;
    nx = det3(b[0], a[0][1], a[0][2], b[1], a[1][1], a[1][2], b[2], a[2][1], a[2][2]);
    ny = det3(a[0][0], b[0], a[0][2], a[1][0], b[1], a[1][2], a[2][0], b[2], a[2][2]);
    nz = det3(a[0][0], a[0][1], b[0], a[1][0], a[1][1], b[1], a[2][0], a[2][1], b[2]);
    d = d <<< SHD;
    last_px = quot_sat(nx <<< SHN, d);
    last_py = quot_sat(ny <<< SHN, d);
    last_pz = quot_sat(nz <<< SHN, d);
    return ST_OK;
  endfunction

  function automatic void predict_report(report_t r);
    fix_t f;
    if (r.seen && r.rssi != 0) keep_anchor(r);
    if (!r.last) return;
    f.st = solve_fix();
    kept_n = 0;
    f.px = last_px; f.py = last_py; f.pz = last_pz;
    expected_fixes.insert(expected_fixes.size(), f);
  endfunction

  function automatic void add_report(int x, int y, int z, int rng, int rssi,
                                     bit seen, bit last);
    report_t r;
    r.x = CW'(x); r.y = CW'(y); r.z = CW'(z); r.rng = RW'(rng); r.rssi = SW'(rssi);
    r.seen = seen; r.last = last;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic int pick_coord(bit wide);
    if (wide) return $signed($urandom_range(0, 1048575) - 524288);
    return $signed($urandom_range(0, 8191) - 4096);
  endfunction

  function automatic int pick_rssi();
    int s;
    s = $signed($urandom_range(0, 255) - 128);
    if (s == 0) s = -70;
    return s;
  endfunction

  // Random batch: mostly well-formed sets of fresh anchors, some short or noisy.
  function automatic int add_batch();
    int n, k, kind, zc;
    bit wide;
    kind = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    n = (kind < 70) ? $urandom_range(4, 7) : $urandom_range(1, 3);
    zc = pick_coord(wide);
    for (k = 0; k < n; k++) begin
      if (kind >= 90)
        add_report(pick_coord(1), pick_coord(1), pick_coord(1),
                   $urandom_range(0, 524287), $signed($urandom_range(0, 255) - 128),
                   $urandom_range(0, 1) == 1, k == n - 1);
      else if (kind >= 80)
        // coplanar anchors, but with too few reports to reach a singular system
        add_report(pick_coord(wide), pick_coord(wide), zc, $urandom_range(0, 524287),
                   pick_rssi(), 1'b1, k == n - 1);
      else
        add_report(pick_coord(wide), pick_coord(wide), pick_coord(wide),
                   wide ? $urandom_range(0, 524287) : $urandom_range(0, 16383),
                   ($urandom_range(0, 9) == 0) ? 0 : pick_rssi(),
                   $urandom_range(0, 9) != 0, k == n - 1);
    end
    return n;
  endfunction

  initial begin
    int total;
    // fewer than four anchors, with an ineligible and an absent report
    add_report(524287, -524288, 0, 524287, 127, 1'b1, 1'b0);
    add_report(1000, 2000, 3000, 100, -50, 1'b0, 1'b0);
    add_report(1000, 2000, 3000, 100, 0, 1'b1, 1'b1);
    // well-posed tetrahedron with a tie and a dropped weak anchor
    add_report(0, 0, 0, 1280, -40, 1'b1, 1'b0);
    add_report(2560, 0, 0, 1810, -40, 1'b1, 1'b0);
    add_report(0, 2560, 0, 1810, -60, 1'b1, 1'b0);
    add_report(0, 0, 2560, 1810, -30, 1'b1, 1'b0);
    add_report(9999, 9999, 9999, 5000, -128, 1'b1, 1'b1);
    // coplanar anchors
    add_report(0, 0, 7, 10, 10, 1'b1, 1'b0);
    add_report(256, 0, 7, 20, 20, 1'b1, 1'b0);
    add_report(0, 256, 7, 30, 30, 1'b1, 1'b0);
    add_report(256, 256, 7, 40, 40, 1'b1, 1'b1);
    // extreme coordinates and ranges, saturating quotient
    add_report(-524288, -524288, -524288, 524287, 127, 1'b1, 1'b0);
    add_report(-524287, -524288, -524288, 0, 126, 1'b1, 1'b0);
    add_report(-524288, -524287, -524288, 0, 125, 1'b1, 1'b0);
    add_report(-524288, -524288, -524287, 0, 1, 1'b1, 1'b0);
    add_report(524287, 524287, 524287, 524287, -1, 1'b1, 1'b1);
    // lone ineligible final report
    add_report(0, 0, 0, 0, 0, 1'b0, 1'b1);
    total = 18;
    while (total < 800) total += add_batch();
    wait (pending_reports.size() == 0 && !in_valid);
    wait (expected_fixes.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("rssi_select_trilateration_solver_unit: match");
    else
      $display("rssi_select_trilateration_solver_unit: mismatch");
    $finish;
  end

  function automatic bit calm();
    return cycle >= CALM_START && cycle < CALM_END;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || report_taken) begin
      if (pending_reports.size() != 0 && (calm() || $urandom_range(0, 99) >= 37)) begin
        report_t r;
        r = pending_reports.pop_front();
        anchor_x <= r.x; anchor_y <= r.y; anchor_z <= r.z;
        anchor_range <= r.rng; signal_strength <= r.rssi;
        recently_seen <= r.seen; last_in_batch <= r.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, one long hold-off counted down here
  always @(negedge clk) begin
    if (cycle == HOLD_START) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !calm() && $urandom_range(0, 99) < 37;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    bit moved;
    fix_t f;
    report_t r;
    moved = 1'b0;
    cycle <= cycle + 1;
    if (cycle == 1) rst <= 1'b0;
    report_taken = !rst && in_valid && !in_stall;
    if (report_taken) begin
      moved = 1'b1;
      r.x = anchor_x; r.y = anchor_y; r.z = anchor_z; r.rng = anchor_range;
      r.rssi = signal_strength; r.seen = recently_seen; r.last = last_in_batch;
      predict_report(r);
    end
    if (!rst && out_valid && !out_stall) begin
      moved = 1'b1;
      if (expected_fixes.size() == 0) begin
        $error("unexpected fix transaction");
        errors++;
      end else begin
        f = expected_fixes.pop_front();
        if (pos_x !== f.px) begin
          $error("pos_x expected %0d actual %0d", f.px, pos_x); errors++;
        end
        if (pos_y !== f.py) begin
          $error("pos_y expected %0d actual %0d", f.py, pos_y); errors++;
        end
        if (pos_z !== f.pz) begin
          $error("pos_z expected %0d actual %0d", f.pz, pos_z); errors++;
        end
        if (status !== f.st) begin
          $error("status expected %0d actual %0d", f.st, status); errors++;
        end
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rssi_select_trilateration_solver_unit: mismatch");
      $finish;
    end
  end

endmodule
